FILE: rtl/lru_page_replacement_top_assert.svh
// Assertion macros used by the LRU page replacement top level.
`ifndef LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LRUPR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("lru page replacement: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LRUPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("lru page replacement: next-cycle check failed");

`endif

FILE: rtl/lrupr_pkg.sv
// Package with types and constants of the LRU page replacement block.
package lrupr_pkg;

	localparam int FRAME_DEPTH_DEF = 8;
	localparam int PAGE_BITS_DEF   = 16;
	localparam int STAMP_BITS_DEF  = 32;
	localparam int COUNT_BITS      = 32;
	localparam int CFG_BITS        = 4;

	localparam logic [CFG_BITS-1:0] FRAMES_RESET = 4'd8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} lrupr_state_t;

endpackage

FILE: rtl/lru_page_replacement_top.sv
// LRU page replacement top level: frame table, access clock and fault counter.
// Each item passes the states accept (idle), scan over the clamped frames_in_use frames
// through the tag and stamp RAM read port, and update, which waits for a free output.
// A new item is accepted only in idle, after the last item has updated; the result waits
// in an output register, so the next item can be accepted while it is pending.
// Reset clears valid bits, access clock, fault count and sets frames_in_use to 8.
`include "lru_page_replacement_top_assert.svh"

module lru_page_replacement_top #(
	parameter int FRAME_DEPTH = lrupr_pkg::FRAME_DEPTH_DEF,
	parameter int PAGE_BITS   = lrupr_pkg::PAGE_BITS_DEF,
	parameter int STAMP_BITS  = lrupr_pkg::STAMP_BITS_DEF,
	localparam int IDX_W = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lrupr_pkg::CFG_BITS-1:0]  cfg_data,

	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [PAGE_BITS-1:0]            page_number,

	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            hit,
	output logic [IDX_W-1:0]                frame_index,
	output logic                            evicted_valid,
	output logic [PAGE_BITS-1:0]            evicted_page,
	output logic [lrupr_pkg::COUNT_BITS-1:0] fault_total,
	output logic                            clock_saturated
);

	import lrupr_pkg::*;

	localparam int CNT_W = $clog2(FRAME_DEPTH + 1);
	localparam int CW    = (CNT_W > CFG_BITS) ? CNT_W : CFG_BITS;

	lrupr_state_t state_q, state_d;

	logic [CFG_BITS-1:0]   frames_in_use_q;
	logic [CNT_W-1:0]      n_q, n_next;
	logic [CNT_W-1:0]      j_q;
	logic [PAGE_BITS-1:0]  page_q;
	logic [FRAME_DEPTH-1:0] valid_q;

	logic                  hit_found_q, emp_found_q, best_have_q;
	logic [IDX_W-1:0]      hit_idx_q, emp_idx_q, best_idx_q;
	logic [STAMP_BITS-1:0] best_stamp_q;
	logic [PAGE_BITS-1:0]  best_tag_q;

	logic [STAMP_BITS-1:0] access_clock_q, clock_next;
	logic [COUNT_BITS-1:0] fault_count_q, fault_next;

	logic                  out_valid_q;
	logic                  hit_q, evicted_valid_q, clock_sat_q;
	logic [IDX_W-1:0]      frame_index_q;
	logic [PAGE_BITS-1:0]  evicted_page_q;
	logic [COUNT_BITS-1:0] fault_total_q;

	logic                  in_fire, upd_fire, out_free;
	logic [CW-1:0]         cfg_ext, depth_ext;
	logic [IDX_W-1:0]      rd_addr, k_idx, vic_idx;
	logic [PAGE_BITS-1:0]  rd_tag;
	logic [STAMP_BITS-1:0] rd_stamp;
	logic                  k_valid, tag_match, stamp_lt, miss, evict;

	// Tag and stamp RAMs share the scan address and the update write address.
	lrupr_ram #(.WIDTH(PAGE_BITS), .DEPTH(FRAME_DEPTH)) u_tag_ram (
		.clk   (clk),
		.we    (upd_fire && miss),
		.waddr (vic_idx),
		.wdata (page_q),
		.raddr (rd_addr),
		.rdata (rd_tag)
	);

	lrupr_ram #(.WIDTH(STAMP_BITS), .DEPTH(FRAME_DEPTH)) u_stamp_ram (
		.clk   (clk),
		.we    (upd_fire),
		.waddr (vic_idx),
		.wdata (access_clock_q),
		.raddr (rd_addr),
		.rdata (rd_stamp)
	);

	// Clamp the configured frame count into 1..FRAME_DEPTH.
	always_comb begin
		cfg_ext   = CW'(frames_in_use_q);
		depth_ext = CW'(FRAME_DEPTH);
		if (cfg_ext == '0) begin
			n_next = CNT_W'(1);
		end else if (cfg_ext > depth_ext) begin
			n_next = CNT_W'(FRAME_DEPTH);
		end else begin
			n_next = CNT_W'(cfg_ext);
		end
	end

	// The read issued in the accept cycle fetches frame 0; each scan cycle
	// compares frame j-1 and fetches frame j.
	always_comb begin
		if (state_q == ST_SCAN && j_q < n_q) begin
			rd_addr = j_q[IDX_W-1:0];
		end else begin
			rd_addr = '0;
		end
		k_idx     = IDX_W'(j_q - CNT_W'(1));
		k_valid   = valid_q[k_idx];
		tag_match = k_valid && (rd_tag == page_q);
		stamp_lt  = rd_stamp < best_stamp_q;
	end

	always_comb begin
		miss  = !hit_found_q;
		evict = miss && !emp_found_q;
		priority if (hit_found_q) begin
			vic_idx = hit_idx_q;
		end else if (emp_found_q) begin
			vic_idx = emp_idx_q;
		end else begin
			vic_idx = best_idx_q;
		end
		clock_next = (&access_clock_q) ? access_clock_q : access_clock_q + STAMP_BITS'(1);
		fault_next = (miss && !(&fault_count_q)) ? fault_count_q + COUNT_BITS'(1)
			: fault_count_q;
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		out_free = !out_valid_q || out_ready;
		upd_fire = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (j_q == n_q) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (out_free) begin
					upd_fire = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= FRAMES_RESET;
			valid_q         <= '0;
			access_clock_q  <= '0;
			fault_count_q   <= '0;
			out_valid_q     <= 1'b0;
			hit_found_q     <= 1'b0;
			emp_found_q     <= 1'b0;
			best_have_q     <= 1'b0;
			j_q             <= '0;
			n_q             <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				frames_in_use_q <= cfg_data;
			end
			if (upd_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (in_fire) begin
				n_q         <= n_next;
				j_q         <= CNT_W'(1);
				hit_found_q <= 1'b0;
				emp_found_q <= 1'b0;
				best_have_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				if (j_q != n_q) begin
					j_q <= j_q + CNT_W'(1);
				end
				if (tag_match && !hit_found_q) begin
					hit_found_q <= 1'b1;
				end
				if (!k_valid && !emp_found_q) begin
					emp_found_q <= 1'b1;
				end
				if (k_valid && (!best_have_q || stamp_lt)) begin
					best_have_q <= 1'b1;
				end
			end
			if (upd_fire) begin
				valid_q[vic_idx] <= 1'b1;
				access_clock_q   <= clock_next;
				fault_count_q    <= fault_next;
			end
		end
	end

	// Payload registers: the page, scan results and the result item.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			page_q <= page_number;
		end
		if (state_q == ST_SCAN) begin
			if (tag_match && !hit_found_q) begin
				hit_idx_q <= k_idx;
			end
			if (!k_valid && !emp_found_q) begin
				emp_idx_q <= k_idx;
			end
			if (k_valid && (!best_have_q || stamp_lt)) begin
				best_idx_q   <= k_idx;
				best_stamp_q <= rd_stamp;
				best_tag_q   <= rd_tag;
			end
		end
		if (upd_fire) begin
			hit_q           <= hit_found_q;
			frame_index_q   <= vic_idx;
			evicted_valid_q <= evict;
			evicted_page_q  <= evict ? best_tag_q : '0;
			fault_total_q   <= fault_next;
			clock_sat_q     <= &clock_next;
		end
	end

	assign out_valid       = out_valid_q;
	assign hit             = hit_q;
	assign frame_index     = frame_index_q;
	assign evicted_valid   = evicted_valid_q;
	assign evicted_page    = evicted_page_q;
	assign fault_total     = fault_total_q;
	assign clock_saturated = clock_sat_q;

	`LRUPR_ASSERT_NEXT(a_accept_starts_scan, clk, arst_n, in_fire, state_q == ST_SCAN)
	`LRUPR_ASSERT_SAME(a_hit_frame_valid, clk, arst_n, hit_found_q, valid_q[hit_idx_q])
	`LRUPR_ASSERT_SAME(a_fault_counted, clk, arst_n, out_valid_q && !hit_q, fault_total_q != '0)
	`LRUPR_ASSERT_NEXT(a_sat_sticky, clk, arst_n, out_valid_q && clock_sat_q, clock_sat_q)

endmodule

FILE: rtl/lrupr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lrupr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: tb/lru_page_replacement_top_tb.sv
// Self-checking testbench for the LRU page replacement block with a timestamp predictor.
module lru_page_replacement_top_tb;

	import lrupr_pkg::*;

	localparam int DEPTH   = FRAME_DEPTH_DEF;
	localparam int PAGE_W  = PAGE_BITS_DEF;
	localparam int STAMP_W = STAMP_BITS_DEF;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef struct packed {
		logic                  hit;
		logic [IDX_W-1:0]      frame;
		logic                  evicted;
		logic [PAGE_W-1:0]     victim;
		logic [COUNT_BITS-1:0] faults;
		logic                  saturated;
	} access_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_BITS-1:0]   cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [PAGE_W-1:0]     page_number;
	logic                  out_valid;
	logic                  out_ready;
	logic                  hit;
	logic [IDX_W-1:0]      frame_index;
	logic                  evicted_valid;
	logic [PAGE_W-1:0]     evicted_page;
	logic [COUNT_BITS-1:0] fault_total;
	logic                  clock_saturated;

	// Predictor state: the frame table, the access clock and the fault counter.
	logic [CFG_BITS-1:0]   frames_cfg;
	logic [PAGE_W-1:0]     tag_page [DEPTH];
	logic                  tag_valid [DEPTH];
	logic [STAMP_W-1:0]    use_stamp [DEPTH];
	logic [STAMP_W-1:0]    access_clk;
	logic [COUNT_BITS-1:0] fault_cnt;

	access_result_t pending_results [$];
	access_result_t got_result;
	access_result_t want_result;
	int             err_count;
	int             burst_left;
	bit             gaps_on;
	logic [PAGE_W-1:0] page_pool [16];
	int             pool_size;

	lru_page_replacement_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.page_number     (page_number),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.hit             (hit),
		.frame_index     (frame_index),
		.evicted_valid   (evicted_valid),
		.evicted_page    (evicted_page),
		.fault_total     (fault_total),
		.clock_saturated (clock_saturated)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// One page reference against the frame table; updates the predictor state.
	function automatic access_result_t lru_lookup(input logic [PAGE_W-1:0] page);
		access_result_t r;
		int n;
		int idx;
		int j;
		bit found;
		bit empty;
		logic [STAMP_W-1:0] best;
		n = (frames_cfg == 0) ? 1 : ((frames_cfg > DEPTH) ? DEPTH : int'(frames_cfg));
		r = '0;
		idx = 0;
		found = 1'b0;
		empty = 1'b0;
		for (j = 0; j < n; j++) begin
			if (!found && tag_valid[j] && tag_page[j] == page) begin
				found = 1'b1;
				idx = j;
			end
		end
		if (!found) begin
			for (j = 0; j < n; j++) begin
				if (!empty && !tag_valid[j]) begin
					empty = 1'b1;
					idx = j;
				end
			end
			if (!empty) begin
				// All frames in range are valid; the first smallest stamp loses.
				best = use_stamp[0];
				idx = 0;
				for (j = 1; j < n; j++) begin
					if (use_stamp[j] < best) begin
						best = use_stamp[j];
						idx = j;
					end
				end
				r.evicted = 1'b1;
				r.victim = tag_page[idx];
			end
			tag_page[idx] = page;
			tag_valid[idx] = 1'b1;
			if (fault_cnt != '1)
				fault_cnt = fault_cnt + 1'b1;
		end
		use_stamp[idx] = access_clk;
		if (access_clk != '1)
			access_clk = access_clk + 1'b1;
		r.hit = found;
		r.frame = idx[IDX_W-1:0];
		r.faults = fault_cnt;
		r.saturated = (access_clk == '1);
		return r;
	endfunction

	function automatic void note_error(input string what);
		err_count++;
		if (err_count <= 10)
			$display("%0t mismatch: %s", $realtime, what);
	endfunction

	// Result checker: every transfer on the output side is matched to the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_result = '{hit, frame_index, evicted_valid, evicted_page, fault_total,
				clock_saturated};
			if (pending_results.size() == 0) begin
				note_error($sformatf("result with nothing expected: %p", got_result));
			end else begin
				want_result = pending_results.pop_front();
				if (got_result.hit !== want_result.hit)
					note_error($sformatf("hit exp %b got %b", want_result.hit, got_result.hit));
				if (got_result.frame !== want_result.frame)
					note_error($sformatf("frame_index exp %0d got %0d",
						want_result.frame, got_result.frame));
				if (got_result.evicted !== want_result.evicted)
					note_error($sformatf("evicted_valid exp %b got %b",
						want_result.evicted, got_result.evicted));
				if (got_result.victim !== want_result.victim)
					note_error($sformatf("evicted_page exp %h got %h",
						want_result.victim, got_result.victim));
				if (got_result.faults !== want_result.faults)
					note_error($sformatf("fault_total exp %0d got %0d",
						want_result.faults, got_result.faults));
				if (got_result.saturated !== want_result.saturated)
					note_error($sformatf("clock_saturated exp %b got %b",
						want_result.saturated, got_result.saturated));
			end
		end
	end

	// Receiver: the stall pattern switches between styles every so often.
	initial begin : receiver
		int mode;
		int span;
		int hold;
		int step;
		logic [7:0] pat;
		out_ready = 1'b0;
		mode = 0;
		span = 0;
		hold = 0;
		step = 0;
		pat = 8'hFF;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (span == 0) begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(30, 200);
				pat = 8'($urandom_range(1, 255));
			end
			span--;
			step++;
			case (mode)
				0: begin
					out_ready = 1'b1;
				end
				1: begin
					out_ready = 1'($urandom_range(0, 1));
				end
				2: begin
					out_ready = pat[step[2:0]];
				end
				default: begin
					if (hold == 0)
						hold = $urandom_range(1, 20);
					hold--;
					out_ready = (hold < 3);
				end
			endcase
		end
	end

	// Lowers valid and waits until every predicted result has arrived and the block is quiet.
	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_frames(input logic [CFG_BITS-1:0] value);
		wait_idle();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		frames_cfg = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_page(input logic [PAGE_W-1:0] page);
		int gap;
		if (gaps_on) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 12);
				@(negedge clk);
				in_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
				burst_left = $urandom_range(1, 24);
			end else begin
				burst_left--;
			end
		end
		@(negedge clk);
		in_valid = 1'b1;
		page_number = page;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(lru_lookup(page));
	endtask

	// Fill all eight frames from empty, with all-zero and all-one pages, then hit twice.
	task automatic test_fill_and_hit();
		send_page(16'h0000);
		send_page(16'hFFFF);
		send_page(16'h00FF);
		send_page(16'hFF00);
		send_page(16'h1234);
		send_page(16'h5555);
		send_page(16'hAAAA);
		send_page(16'h8001);
		send_page(16'h0000);
		send_page(16'hAAAA);
	endtask

	// A full table forces replacement of the least recently used frames.
	task automatic test_lru_eviction();
		send_page(16'h4321);
		send_page(16'h7FFF);
		send_page(16'h00FF);
	endtask

	// Frame limits at the edges: zero acts as one, above the depth acts as the depth.
	task automatic test_frame_limits();
		write_frames(4'd1);
		send_page(16'h0000);
		send_page(16'hBEEF);
		send_page(16'hBEEF);
		write_frames(4'd0);
		send_page(16'h0F0F);
		send_page(16'h0F0F);
		write_frames(4'd15);
		send_page(16'h5555);
		send_page(16'hF0F0);
	endtask

	// Frames beyond a reduced limit keep their pages and come back when it grows.
	task automatic test_shrink_and_grow();
		write_frames(4'd2);
		send_page(16'hAAAA);
		send_page(16'h1234);
		write_frames(4'd8);
		send_page(16'h1234);
		send_page(16'hAAAA);
	endtask

	// Most pages come from a small working set so hits and evictions both happen often.
	task automatic test_random_traffic();
		int ph;
		int k;
		int count;
		logic [CFG_BITS-1:0] cfg;
		for (ph = 0; ph < 8; ph++) begin
			case (ph)
				0: cfg = 4'd8;
				1: cfg = 4'd15;
				2: cfg = 4'd1;
				default: cfg = CFG_BITS'($urandom_range(0, 15));
			endcase
			write_frames(cfg);
			pool_size = $urandom_range(2, 16);
			for (k = 0; k < 16; k++)
				page_pool[k] = PAGE_W'($urandom_range(0, 16'hFFFF));
			gaps_on = (ph % 3 != 1);
			burst_left = $urandom_range(0, 10);
			count = $urandom_range(190, 220);
			for (k = 0; k < count; k++) begin
				if ($urandom_range(0, 9) < 8)
					send_page(page_pool[$urandom_range(0, pool_size - 1)]);
				else
					send_page(PAGE_W'($urandom_range(0, 16'hFFFF)));
			end
		end
	endtask

	initial begin : main
		int k;
		clk_init: begin
			arst_n = 1'b0;
			cfg_valid = 1'b0;
			cfg_data = '0;
			in_valid = 1'b0;
			page_number = '0;
		end
		err_count = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		frames_cfg = FRAMES_RESET;
		for (k = 0; k < DEPTH; k++) begin
			tag_page[k] = '0;
			tag_valid[k] = 1'b0;
			use_stamp[k] = '0;
		end
		access_clk = '0;
		fault_cnt = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Access clock and fault count saturation need 2^32 references and are out of reach;
		// the predictor still models them, so the flag is checked low throughout.
		test_fill_and_hit();
		test_lru_eviction();
		test_frame_limits();
		test_shrink_and_grow();
		test_random_traffic();

		wait_idle();
		if (pending_results.size() != 0)
			note_error($sformatf("%0d results never arrived", pending_results.size()));
		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/lrupr_pkg.sv
rtl/lrupr_ram.sv
rtl/lru_page_replacement_top.sv
tb/lru_page_replacement_top_tb.sv
